// File: sv/vcs_pkg.sv
// shared types and constants for the vector cosine similarity block
package vcs_pkg;

    localparam int DOT_W  = 38;
    localparam int SUM_W  = 37;
    localparam int LEN_W  = 27;
    localparam int COS_W  = 16;
    localparam int ELEM_W = 16;

    // iterative unit widths
    localparam int SRC_W  = 74;
    localparam int REM_W  = 76;
    localparam int ARG_W  = 38;
    localparam int RES_W  = 53;
    localparam int CNT_W  = 6;

    // iteration counts per operation
    localparam logic [CNT_W-1:0] MUL_STEPS  = 6'd37;
    localparam logic [CNT_W-1:0] SQRT_STEPS = 6'd37;
    localparam logic [CNT_W-1:0] DIV_STEPS  = 6'd53;

    localparam logic [1:0] STATUS_OK   = 2'd0;
    localparam logic [1:0] STATUS_ZERO = 2'd1;
    localparam logic [1:0] STATUS_OVF  = 2'd2;

    typedef enum logic [1:0] {
        OP_MUL  = 2'd0,
        OP_SQRT = 2'd1,
        OP_DIV  = 2'd2
    } unit_op_t;

    typedef struct packed {
        logic     start;
        unit_op_t op;
    } unit_cmd_t;

    typedef struct packed {
        logic accept;
        logic clear;
    } acc_ctl_t;

endpackage

// File: sv/vcs_acc.sv
// dot product and square sum accumulators with element count
module vcs_acc #(
    parameter int MAX_ELEMENTS = 64
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  vcs_pkg::acc_ctl_t                ctl,
    input  logic signed [vcs_pkg::ELEM_W-1:0] u_elem,
    input  logic signed [vcs_pkg::ELEM_W-1:0] v_elem,
    output logic signed [vcs_pkg::DOT_W-1:0] dot,
    output logic [vcs_pkg::SUM_W-1:0]        sum_u,
    output logic [vcs_pkg::SUM_W-1:0]        sum_v,
    output logic                             ovf
);

    localparam int CW = $clog2(MAX_ELEMENTS + 1);

    logic signed [vcs_pkg::DOT_W-1:0] dot_reg, dot_next;
    logic [vcs_pkg::SUM_W-1:0]        su_reg, su_next;
    logic [vcs_pkg::SUM_W-1:0]        sv_reg, sv_next;
    logic [CW-1:0]                    cnt_reg, cnt_next;
    logic                             ovf_reg, ovf_next;
    logic signed [31:0]               p_uv;
    logic signed [31:0]               p_uu;
    logic signed [31:0]               p_vv;

    assign p_uv = u_elem * v_elem;
    assign p_uu = u_elem * u_elem;
    assign p_vv = v_elem * v_elem;

    always_comb
    begin
        dot_next = dot_reg;
        su_next  = su_reg;
        sv_next  = sv_reg;
        cnt_next = cnt_reg;
        ovf_next = ovf_reg;
        if (ctl.clear)
        begin
            dot_next = '0;
            su_next  = '0;
            sv_next  = '0;
            cnt_next = '0;
            ovf_next = 1'b0;
        end
        else if (ctl.accept)
        begin
            if (cnt_reg < CW'(MAX_ELEMENTS))
            begin
                dot_next = dot_reg + {{(vcs_pkg::DOT_W-32){p_uv[31]}}, p_uv};
                su_next  = su_reg + {{(vcs_pkg::SUM_W-32){1'b0}}, p_uu};
                sv_next  = sv_reg + {{(vcs_pkg::SUM_W-32){1'b0}}, p_vv};
                cnt_next = cnt_reg + 1'b1;
            end
            else
            begin
                ovf_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dot_reg <= '0;
            su_reg  <= '0;
            sv_reg  <= '0;
            cnt_reg <= '0;
            ovf_reg <= 1'b0;
        end
        else
        begin
            dot_reg <= dot_next;
            su_reg  <= su_next;
            sv_reg  <= sv_next;
            cnt_reg <= cnt_next;
            ovf_reg <= ovf_next;
        end
    end

    assign dot   = dot_reg;
    assign sum_u = su_reg;
    assign sum_v = sv_reg;
    assign ovf   = ovf_reg;

endmodule

// File: sv/vcs_unit.sv
// shared bit-serial multiply, square root and divide unit on one adder
module vcs_unit (
    input  logic                        clk,
    input  logic                        rst_n,
    input  vcs_pkg::unit_cmd_t          cmd,
    input  logic [vcs_pkg::SRC_W-1:0]   src_in,
    input  logic [vcs_pkg::ARG_W-1:0]   arg_in,
    output logic                        done,
    output logic [vcs_pkg::SRC_W-1:0]   product,
    output logic [vcs_pkg::RES_W-1:0]   result
);

    localparam int RW = vcs_pkg::REM_W;

    vcs_pkg::unit_op_t               op_reg, op_next;
    logic                            busy_reg, busy_next;
    logic                            done_reg, done_next;
    logic [vcs_pkg::CNT_W-1:0]       cnt_reg, cnt_next;
    logic [RW-1:0]                   rem_reg, rem_next;
    logic [vcs_pkg::SRC_W-1:0]       src_reg, src_next;
    logic [vcs_pkg::RES_W-1:0]       res_reg, res_next;
    logic [vcs_pkg::ARG_W-1:0]       arg_reg, arg_next;
    logic [RW-1:0]                   x;
    logic [RW-1:0]                   y;
    logic                            sub;
    logic [RW:0]                     sum;
    logic                            fits;

    // operand selection for the one shared adder
    always_comb
    begin
        x   = '0;
        y   = '0;
        sub = 1'b0;
        case (op_reg)
            vcs_pkg::OP_MUL:
            begin
                x = {rem_reg[RW-2:0], 1'b0};
                y = src_reg[vcs_pkg::SRC_W-1] ? {{(RW-vcs_pkg::ARG_W){1'b0}}, arg_reg} : '0;
            end
            vcs_pkg::OP_SQRT:
            begin
                x   = {rem_reg[RW-3:0], src_reg[vcs_pkg::SRC_W-1 -: 2]};
                y   = {{(RW-vcs_pkg::RES_W-2){1'b0}}, res_reg, 2'b01};
                sub = 1'b1;
            end
            vcs_pkg::OP_DIV:
            begin
                x   = {rem_reg[RW-2:0], src_reg[vcs_pkg::SRC_W-1]};
                y   = {{(RW-vcs_pkg::ARG_W){1'b0}}, arg_reg};
                sub = 1'b1;
            end
            default:
            begin
                x   = '0;
                y   = '0;
                sub = 1'b0;
            end
        endcase
        sum  = {1'b0, x} + {1'b0, (sub ? ~y : y)} + {{RW{1'b0}}, sub};
        // carry out of the subtract means no borrow
        fits = sum[RW];
    end

    always_comb
    begin
        op_next   = op_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        src_next  = src_reg;
        res_next  = res_reg;
        arg_next  = arg_reg;
        if (cmd.start)
        begin
            op_next   = cmd.op;
            busy_next = 1'b1;
            rem_next  = '0;
            res_next  = '0;
            src_next  = src_in;
            arg_next  = arg_in;
            case (cmd.op)
                vcs_pkg::OP_MUL:  cnt_next = vcs_pkg::MUL_STEPS;
                vcs_pkg::OP_SQRT: cnt_next = vcs_pkg::SQRT_STEPS;
                vcs_pkg::OP_DIV:  cnt_next = vcs_pkg::DIV_STEPS;
                default:          cnt_next = vcs_pkg::MUL_STEPS;
            endcase
        end
        else if (busy_reg)
        begin
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == vcs_pkg::CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
            case (op_reg)
                vcs_pkg::OP_MUL:
                begin
                    rem_next = sum[RW-1:0];
                    src_next = {src_reg[vcs_pkg::SRC_W-2:0], 1'b0};
                end
                vcs_pkg::OP_SQRT:
                begin
                    rem_next = fits ? sum[RW-1:0] : x;
                    res_next = {res_reg[vcs_pkg::RES_W-2:0], fits};
                    src_next = {src_reg[vcs_pkg::SRC_W-3:0], 2'b00};
                end
                vcs_pkg::OP_DIV:
                begin
                    rem_next = fits ? sum[RW-1:0] : x;
                    res_next = {res_reg[vcs_pkg::RES_W-2:0], fits};
                    src_next = {src_reg[vcs_pkg::SRC_W-2:0], 1'b0};
                end
                default:
                begin
                    rem_next = rem_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            op_reg   <= vcs_pkg::OP_MUL;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            op_reg   <= op_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        src_reg <= src_next;
        res_reg <= res_next;
        arg_reg <= arg_next;
    end

    assign done    = done_reg;
    assign product = rem_reg[vcs_pkg::SRC_W-1:0];
    assign result  = res_reg;

endmodule

// File: sv/vector_cosine_similarity.sv
// top level: accumulation, post-processing sequencer and output register
//
// Input channel: one coordinate pair (u_elem, v_elem) per request, with last
// on the final pair. Pairs that are not last are taken one per cycle and
// summed straight into the accumulators.
// After a last pair the block raises in_stall and runs one shared bit-serial
// unit: sumU*sumV (37 steps), three square roots (37 steps each) and one
// division (53 steps); the division is skipped when either length is zero,
// and with too many elements the unit is not run at all.
// Output channel: one request per vector pair, held in an output register.
// While it waits under out_stall, new pairs for the next vectors are still
// taken; a later last pair waits in the final state until the register frees.
// Reset clears the accumulators, the sequencer and the output valid.
module vector_cosine_similarity #(
    parameter int MAX_ELEMENTS = 64
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_stall,
    input  logic signed [vcs_pkg::ELEM_W-1:0] u_elem,
    input  logic signed [vcs_pkg::ELEM_W-1:0] v_elem,
    input  logic                             last,
    output logic                             out_valid,
    input  logic                             out_stall,
    output logic signed [vcs_pkg::DOT_W-1:0] dot_product,
    output logic [vcs_pkg::LEN_W-1:0]        length_u,
    output logic [vcs_pkg::LEN_W-1:0]        length_v,
    output logic signed [vcs_pkg::COS_W-1:0] cosine,
    output logic [1:0]                       status
);

    typedef enum logic [7:0] {
        ST_ACC    = 8'b0000_0001,
        ST_START  = 8'b0000_0010,
        ST_MUL    = 8'b0000_0100,
        ST_ROOT_P = 8'b0000_1000,
        ST_ROOT_U = 8'b0001_0000,
        ST_ROOT_V = 8'b0010_0000,
        ST_DIV    = 8'b0100_0000,
        ST_FIN    = 8'b1000_0000
    } state_t;

    state_t                            state_reg, state_next;
    vcs_pkg::acc_ctl_t                 acc_ctl;
    vcs_pkg::unit_cmd_t                cmd;
    logic [vcs_pkg::SRC_W-1:0]         src;
    logic [vcs_pkg::ARG_W-1:0]         arg;
    logic                              unit_done;
    logic [vcs_pkg::SRC_W-1:0]         unit_prod;
    logic [vcs_pkg::RES_W-1:0]         unit_res;
    logic signed [vcs_pkg::DOT_W-1:0]  dot;
    logic [vcs_pkg::SUM_W-1:0]         sum_u;
    logic [vcs_pkg::SUM_W-1:0]         sum_v;
    logic                              ovf;
    logic                              zero_len;
    logic [vcs_pkg::DOT_W-1:0]         mag;
    logic                              in_acc;
    logic                              out_acc;
    logic                              load;
    logic signed [vcs_pkg::COS_W-1:0]  cos_val;

    logic [vcs_pkg::SUM_W-1:0]         den_reg, den_next;
    logic [vcs_pkg::LEN_W-1:0]         len_u_reg, len_u_next;
    logic [vcs_pkg::LEN_W-1:0]         len_v_reg, len_v_next;
    logic signed [vcs_pkg::COS_W-1:0]  cos_reg, cos_next;
    logic                              out_valid_reg, out_valid_next;
    logic signed [vcs_pkg::DOT_W-1:0]  dot_out_reg, dot_out_next;
    logic [vcs_pkg::LEN_W-1:0]         lu_out_reg, lu_out_next;
    logic [vcs_pkg::LEN_W-1:0]         lv_out_reg, lv_out_next;
    logic signed [vcs_pkg::COS_W-1:0]  cos_out_reg, cos_out_next;
    logic [1:0]                        stat_out_reg, stat_out_next;

    assign in_stall = (state_reg != ST_ACC);
    assign in_acc   = in_valid && !in_stall;
    assign out_acc  = out_valid_reg && !out_stall;
    assign zero_len = (sum_u == '0) || (sum_v == '0);
    assign mag      = dot[vcs_pkg::DOT_W-1] ? (~dot + 1'b1) : dot;
    assign load     = (state_reg == ST_FIN) && (!out_valid_reg || !out_stall);

    vcs_acc #(
        .MAX_ELEMENTS (MAX_ELEMENTS)
    ) u_acc (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctl    (acc_ctl),
        .u_elem (u_elem),
        .v_elem (v_elem),
        .dot    (dot),
        .sum_u  (sum_u),
        .sum_v  (sum_v),
        .ovf    (ovf)
    );

    vcs_unit u_unit (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (cmd),
        .src_in  (src),
        .arg_in  (arg),
        .done    (unit_done),
        .product (unit_prod),
        .result  (unit_res)
    );

    // saturate the quotient to q1.15 with the sign of the dot product
    always_comb
    begin
        if (dot[vcs_pkg::DOT_W-1])
        begin
            if (unit_res > vcs_pkg::RES_W'(32768))
                cos_val = 16'sh8000;
            else
                cos_val = -$signed(unit_res[vcs_pkg::COS_W-1:0]);
        end
        else
        begin
            if (unit_res > vcs_pkg::RES_W'(32767))
                cos_val = 16'sh7fff;
            else
                cos_val = $signed(unit_res[vcs_pkg::COS_W-1:0]);
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        acc_ctl.accept = in_acc;
        acc_ctl.clear  = 1'b0;
        cmd.start      = 1'b0;
        cmd.op         = vcs_pkg::OP_MUL;
        src            = {sum_v, {(vcs_pkg::SRC_W-vcs_pkg::SUM_W){1'b0}}};
        arg            = {1'b0, sum_u};
        den_next       = den_reg;
        len_u_next     = len_u_reg;
        len_v_next     = len_v_reg;
        cos_next       = cos_reg;
        case (state_reg)
            ST_ACC:
            begin
                if (in_acc && last)
                    state_next = ST_START;
            end
            ST_START:
            begin
                if (ovf)
                begin
                    state_next = ST_FIN;
                end
                else
                begin
                    cmd.start  = 1'b1;
                    cmd.op     = vcs_pkg::OP_MUL;
                    state_next = ST_MUL;
                end
            end
            ST_MUL:
            begin
                src = unit_prod;
                if (unit_done)
                begin
                    cmd.start  = 1'b1;
                    cmd.op     = vcs_pkg::OP_SQRT;
                    state_next = ST_ROOT_P;
                end
            end
            ST_ROOT_P:
            begin
                src = {21'b0, sum_u, 16'b0};
                if (unit_done)
                begin
                    den_next   = unit_res[vcs_pkg::SUM_W-1:0];
                    cmd.start  = 1'b1;
                    cmd.op     = vcs_pkg::OP_SQRT;
                    state_next = ST_ROOT_U;
                end
            end
            ST_ROOT_U:
            begin
                src = {21'b0, sum_v, 16'b0};
                if (unit_done)
                begin
                    len_u_next = unit_res[vcs_pkg::LEN_W-1:0];
                    cmd.start  = 1'b1;
                    cmd.op     = vcs_pkg::OP_SQRT;
                    state_next = ST_ROOT_V;
                end
            end
            ST_ROOT_V:
            begin
                src = {mag, {(vcs_pkg::SRC_W-vcs_pkg::DOT_W){1'b0}}};
                arg = {1'b0, den_reg};
                if (unit_done)
                begin
                    len_v_next = unit_res[vcs_pkg::LEN_W-1:0];
                    if (zero_len)
                    begin
                        cos_next   = '0;
                        state_next = ST_FIN;
                    end
                    else
                    begin
                        cmd.start  = 1'b1;
                        cmd.op     = vcs_pkg::OP_DIV;
                        state_next = ST_DIV;
                    end
                end
            end
            ST_DIV:
            begin
                if (unit_done)
                begin
                    cos_next   = cos_val;
                    state_next = ST_FIN;
                end
            end
            ST_FIN:
            begin
                if (load)
                begin
                    acc_ctl.clear = 1'b1;
                    state_next    = ST_ACC;
                end
            end
            default:
            begin
                state_next = ST_ACC;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        dot_out_next   = dot_out_reg;
        lu_out_next    = lu_out_reg;
        lv_out_next    = lv_out_reg;
        cos_out_next   = cos_out_reg;
        stat_out_next  = stat_out_reg;
        if (out_acc)
            out_valid_next = 1'b0;
        if (load)
        begin
            out_valid_next = 1'b1;
            if (ovf)
            begin
                dot_out_next  = '0;
                lu_out_next   = '0;
                lv_out_next   = '0;
                cos_out_next  = '0;
                stat_out_next = vcs_pkg::STATUS_OVF;
            end
            else
            begin
                dot_out_next  = dot;
                lu_out_next   = len_u_reg;
                lv_out_next   = len_v_reg;
                cos_out_next  = zero_len ? '0 : cos_reg;
                stat_out_next = zero_len ? vcs_pkg::STATUS_ZERO : vcs_pkg::STATUS_OK;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_ACC;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        den_reg      <= den_next;
        len_u_reg    <= len_u_next;
        len_v_reg    <= len_v_next;
        cos_reg      <= cos_next;
        dot_out_reg  <= dot_out_next;
        lu_out_reg   <= lu_out_next;
        lv_out_reg   <= lv_out_next;
        cos_out_reg  <= cos_out_next;
        stat_out_reg <= stat_out_next;
    end

    assign out_valid   = out_valid_reg;
    assign dot_product = dot_out_reg;
    assign length_u    = lu_out_reg;
    assign length_v    = lv_out_reg;
    assign cosine      = cos_out_reg;
    assign status      = stat_out_reg;

    // a new result only comes out of the final state
    a_rise_from_fin: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == ST_FIN))
        else $error("result appeared outside the final state");

    // accumulators are empty once a result has been handed off
    a_clear_after_fin: assert property (@(posedge clk) disable iff (!rst_n)
        $past(load) |-> (dot == '0 && sum_u == '0 && sum_v == '0 && !ovf))
        else $error("accumulators not cleared after result");

    // the shared unit only finishes while the sequencer waits on it
    a_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
        unit_done |-> (state_reg == ST_MUL || state_reg == ST_ROOT_P ||
                       state_reg == ST_ROOT_U || state_reg == ST_ROOT_V ||
                       state_reg == ST_DIV))
        else $error("unit finished with no operation pending");

    // special cases report a zero cosine
    a_cos_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && stat_out_reg != vcs_pkg::STATUS_OK) |-> cos_out_reg == '0)
        else $error("nonzero cosine on a special case");

endmodule
